>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the pulse decoder.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define OWSP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, checked outside of reset.
`define OWSP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/owsp_pkg.sv
// Package for the single-wire sensor pulse decoder: payload types, register
// indexes, status codes and fixed sizes. No dependencies.
`default_nettype none

package owsp_pkg;

  localparam int BYTE_COUNT   = 5;
  localparam int RUN_INDEX_W  = 7;
  localparam int RUN_LENGTH_W = 16;
  localparam int BIT_COUNT_W  = 6;
  localparam int REG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  // Bit bookkeeping limits.
  localparam logic [BIT_COUNT_W-1:0] BITS_STORED = BIT_COUNT_W'(40);
  localparam logic [BIT_COUNT_W-1:0] BITS_MIN    = BIT_COUNT_W'(39);
  localparam logic [BIT_COUNT_W-1:0] BITS_SAT    = BIT_COUNT_W'(63);

  // Data runs start at this run index and are taken on even indexes only.
  localparam logic [RUN_INDEX_W-1:0] FIRST_DATA_RUN = RUN_INDEX_W'(4);

  // Depth of the record queue between the front and back parts.
  localparam int REC_QUEUE_DEPTH = 2;
  localparam int REC_PTR_W       = $clog2(REC_QUEUE_DEPTH);
  localparam int REC_COUNT_W     = $clog2(REC_QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [REG_INDEX_W-1:0] REG_SENSOR_TYPE   = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_BIT_THRESHOLD = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_RUN_TIMEOUT   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic                    SENSOR_TYPE_RESET   = 1'b1;
  localparam logic [RUN_LENGTH_W-1:0] BIT_THRESHOLD_RESET = 16'd200;
  localparam logic [RUN_LENGTH_W-1:0] RUN_TIMEOUT_RESET   = 16'd1000;

  // Sensor types.
  localparam logic SENSOR_NARROW = 1'b0;
  localparam logic SENSOR_WIDE   = 1'b1;

  // Input functions.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_START  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  typedef struct packed {
    logic func;
    logic level;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
    logic [5:0]         bit_total;
    logic [7:0]         byte_zero;
    logic [7:0]         byte_one;
    logic [7:0]         byte_two;
    logic [7:0]         byte_three;
    logic [7:0]         byte_four;
  } result_t;

  typedef struct packed {
    logic                    sensor_type;
    logic [RUN_LENGTH_W-1:0] bit_threshold;
    logic [RUN_LENGTH_W-1:0] run_timeout;
  } cfg_t;

  // One finished read, handed from the front part to the back part.
  typedef struct packed {
    logic                             sensor_type;
    logic [BIT_COUNT_W-1:0]           bit_total;
    logic [BYTE_COUNT-1:0][7:0]       bytes;
  } rec_t;

endpackage

`default_nettype wire

>>> rtl/owsp_front.sv
// Front part of the pulse decoder: takes line samples and start commands,
// measures runs and collects data bits. Depends on owsp_pkg.
`default_nettype none

module owsp_front #(
  parameter int MAX_RUNS = 100
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire owsp_pkg::cfg_t  cfg,
  input  wire logic            accept,
  input  wire owsp_pkg::item_t item,
  output logic                 rec_push,
  output owsp_pkg::rec_t       rec
);
  import owsp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_READ
  } phase_t;

  localparam logic [RUN_INDEX_W-1:0] RUN_LIMIT = RUN_INDEX_W'(MAX_RUNS);

  phase_t                     phase, phase_next;
  logic                       previous_level, previous_level_next;
  logic [RUN_LENGTH_W-1:0]    run_length, run_length_next;
  logic [RUN_INDEX_W-1:0]     run_index, run_index_next;
  logic [BIT_COUNT_W-1:0]     bits_seen, bits_seen_next;
  logic [BYTE_COUNT-1:0][7:0] received_bytes, received_bytes_next;

  logic [RUN_LENGTH_W-1:0]    run_length_inc;
  logic [RUN_INDEX_W-1:0]     run_index_inc;
  logic [2:0]                 byte_sel;
  logic                       data_bit;
  logic                       data_run;
  logic                       finish;

  assign run_length_inc = run_length + RUN_LENGTH_W'(1);
  assign run_index_inc  = run_index + RUN_INDEX_W'(1);
  assign byte_sel       = bits_seen[5:3];
  assign data_bit       = (run_length > cfg.bit_threshold);
  assign data_run       = (run_index >= FIRST_DATA_RUN) && !run_index[0];

  always_comb begin
    phase_next          = phase;
    previous_level_next = previous_level;
    run_length_next     = run_length;
    run_index_next      = run_index;
    bits_seen_next      = bits_seen;
    received_bytes_next = received_bytes;
    finish              = 1'b0;
    if (accept) begin
      if (item.func == FUNC_START) begin
        received_bytes_next = '0;
        phase_next          = PH_WAIT;
        previous_level_next = 1'b1;
        run_length_next     = '0;
        run_index_next      = '0;
        bits_seen_next      = '0;
      end else begin
        case (phase)
          PH_WAIT: begin
            if (!item.level) begin
              phase_next          = PH_READ;
              previous_level_next = 1'b1;
              run_length_next     = '0;
              run_index_next      = '0;
            end
          end
          PH_READ: begin
            if (item.level == previous_level) begin
              run_length_next = run_length_inc;
              if (run_length_inc == cfg.run_timeout) begin
                finish     = 1'b1;
                phase_next = PH_IDLE;
              end
            end else begin
              if (data_run) begin
                if (bits_seen < BITS_STORED) begin
                  for (int j = 0; j < BYTE_COUNT; j++) begin
                    if (byte_sel == 3'(j)) begin
                      received_bytes_next[j] = {received_bytes[j][6:0], data_bit};
                    end
                  end
                end
                if (bits_seen != BITS_SAT) begin
                  bits_seen_next = bits_seen + BIT_COUNT_W'(1);
                end
              end
              previous_level_next = item.level;
              run_length_next     = '0;
              run_index_next      = run_index_inc;
              if (run_index_inc >= RUN_LIMIT) begin
                finish     = 1'b1;
                phase_next = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The finished read carries the bit count and bytes as updated by the
  // closing sample.
  assign rec_push        = finish;
  assign rec.sensor_type = cfg.sensor_type;
  assign rec.bit_total   = bits_seen_next;
  assign rec.bytes       = received_bytes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      previous_level <= 1'b1;
      run_length     <= '0;
      run_index      <= '0;
      bits_seen      <= '0;
      received_bytes <= '0;
    end else begin
      phase          <= phase_next;
      previous_level <= previous_level_next;
      run_length     <= run_length_next;
      run_index      <= run_index_next;
      bits_seen      <= bits_seen_next;
      received_bytes <= received_bytes_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/owsp_fifo.sv
// Short record queue between the front and back parts of the decoder.
// Depends on owsp_pkg for the record type and queue depth.
`default_nettype none

module owsp_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire owsp_pkg::rec_t wr_data,
  input  wire logic           rd_en,
  output owsp_pkg::rec_t      rd_data,
  output logic                full,
  output logic                empty
);
  import owsp_pkg::*;

  rec_t                   store [REC_QUEUE_DEPTH];
  logic [REC_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [REC_COUNT_W-1:0] count;
  logic                   do_wr, do_rd;

  assign full    = (count == REC_COUNT_W'(REC_QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == REC_PTR_W'(REC_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + REC_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == REC_PTR_W'(REC_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + REC_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + REC_COUNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - REC_COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/owsp_back.sv
// Back part of the decoder: checks bit count and checksum of a finished read,
// scales humidity and temperature, and holds the result register.
// Depends on owsp_pkg.
`default_nettype none

module owsp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           rec_valid,
  input  wire owsp_pkg::rec_t rec,
  output logic                rec_pop,
  input  wire logic           pop,
  output logic                empty,
  output owsp_pkg::result_t   result
);
  import owsp_pkg::*;

  logic [7:0]  b0, b1, b2, b3, b4;
  logic [7:0]  sum;
  logic [15:0] b0_wide, b2_wide, temp_mag;
  logic [1:0]  status;
  logic [15:0] hum;
  logic [15:0] temp;
  logic        res_valid;
  logic        load;
  result_t     res_next;

  assign b0 = rec.bytes[0];
  assign b1 = rec.bytes[1];
  assign b2 = rec.bytes[2];
  assign b3 = rec.bytes[3];
  assign b4 = rec.bytes[4];

  assign sum      = b0 + b1 + b2 + b3;
  assign b0_wide  = {8'd0, b0};
  assign b2_wide  = {8'd0, b2};
  assign temp_mag = {1'b0, b2[6:0], b3};

  always_comb begin
    if (rec.bit_total < BITS_MIN) begin
      status = STATUS_SHORT;
    end else if (b4 != sum) begin
      status = STATUS_CHECKSUM;
    end else begin
      status = STATUS_OK;
    end
    hum  = '0;
    temp = '0;
    if (status == STATUS_OK) begin
      if (rec.sensor_type == SENSOR_NARROW) begin
        // Whole units times ten.
        hum  = (b0_wide << 3) + (b0_wide << 1);
        temp = (b2_wide << 3) + (b2_wide << 1);
      end else begin
        // Tenths, temperature as sign and magnitude.
        hum  = {b0, b1};
        temp = b2[7] ? (16'd0 - temp_mag) : temp_mag;
      end
    end
  end

  always_comb begin
    res_next.status             = status;
    res_next.humidity_tenths    = hum;
    res_next.temperature_tenths = $signed(temp);
    res_next.bit_total          = rec.bit_total;
    res_next.byte_zero          = b0;
    res_next.byte_one           = b1;
    res_next.byte_two           = b2;
    res_next.byte_three         = b3;
    res_next.byte_four          = b4;
  end

  assign load    = rec_valid && (!res_valid || pop);
  assign rec_pop = load;
  assign empty   = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/one_wire_sensor_pulse_decoder.sv
// Single-wire sensor pulse decoder, top level: one line sample per cycle while full is low.
// Throughput: one item per cycle; full rises only when two finished reads
// wait behind a held result.
// A finished read passes through the record queue into the result register, waiting while a result is held.
// Reset (rst, synchronous, active high): idle, no result, registers to 1, 200 and 1000.
// Depends on owsp_pkg, owsp_front, owsp_fifo, owsp_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module one_wire_sensor_pulse_decoder #(
  parameter int MAX_RUNS = 100
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Input queue side.
  input  wire logic                                 push,
  output logic                                      full,
  input  wire owsp_pkg::item_t                      item,
  // Result queue side.
  output logic                                      empty,
  input  wire logic                                 pop,
  output owsp_pkg::result_t                         result,
  // Configuration write channel.
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [owsp_pkg::REG_INDEX_W-1:0]     cfg_index,
  input  wire logic [owsp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import owsp_pkg::*;

  // The decoder has a front part that tracks the line and collects bits, a
  // two-entry record queue, and a back part that checks and scales a finished
  // read into the result register. The front never waits on the back unless
  // the queue is full, so samples keep flowing while a result sits unread.

  cfg_t cfg;
  logic accept;
  logic rec_push;
  rec_t rec_in;
  rec_t rec_head;
  logic q_full, q_empty;
  logic rec_pop;

  // Configuration registers. Writes are always taken; an index beyond the
  // register list is a transaction that changes nothing.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_type   <= SENSOR_TYPE_RESET;
      cfg.bit_threshold <= BIT_THRESHOLD_RESET;
      cfg.run_timeout   <= RUN_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENSOR_TYPE:   cfg.sensor_type   <= cfg_data[0];
        REG_BIT_THRESHOLD: cfg.bit_threshold <= cfg_data;
        REG_RUN_TIMEOUT:   cfg.run_timeout   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A sample could end a read on any cycle, so the input side is held off
  // whenever the record queue cannot take one more finished read.
  assign full   = q_full;
  assign accept = push && !full;

  owsp_front #(
    .MAX_RUNS (MAX_RUNS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .item     (item),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  owsp_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .rd_en   (rec_pop),
    .rd_data (rec_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  owsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!q_empty),
    .rec       (rec_head),
    .rec_pop   (rec_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  // A waiting record reaches the result register whenever that register can
  // take it.
  `OWSP_ASSERT_NEXT(a_record_drains, !q_empty && (empty || pop), !empty)

  // The input side only stalls when finished reads are actually queued.
  `OWSP_ASSERT_IMPL(a_full_needs_records, full, !q_empty)

  // A read that failed a check reports no measurement.
  `OWSP_ASSERT_IMPL(a_failed_read_zero, !empty && result.status != STATUS_OK,
                    result.humidity_tenths == 16'd0 && result.temperature_tenths == 16'sd0)

endmodule

`default_nettype wire
